// File: rtl/core/assert_macros.svh
// Assertion macros for the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/core/lirs_pkg.sv
// Types and constants for the linear interpolation resampler.
package lirs_pkg;

  localparam int SampleBits = 16;
  localparam int Channels   = 2;
  localparam int RateBits   = 18;
  localparam int ResidBits  = 19;
  localparam int FracBits   = 16;
  localparam int QuoBits    = FracBits + 1;
  localparam int NumBits    = RateBits + QuoBits;
  localparam int MaxOut     = 24;
  localparam int CntBits    = 5;
  localparam int CfgIdxBits = 2;
  localparam int ChanBits   = 2;
  localparam int ProdBits   = (SampleBits + 1) + (QuoBits + 1);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSrcRate   = 2'd0,
    CfgDstRate   = 2'd1,
    CfgChanCount = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StChk,
    StDiv,
    StMul,
    StPut
  } state_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_ch0;
    logic signed [SampleBits-1:0] sample_ch1;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] out_ch0;
    logic signed [SampleBits-1:0] out_ch1;
    logic                         last;
  } out_beat_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0] index;
    logic [RateBits-1:0]   data;
  } cfg_beat_t;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic div_step;
    logic mul;
    logic emit;
    logic last;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic resid_lt_dst;
    logic next_lt_dst;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/lirs_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface lirs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lirs_ctrl.sv
// Sequencer: input acceptance, divider iterations and result emission.
`include "assert_macros.svh"

module lirs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lirs_pkg::dp_status_t status_i,
  output lirs_pkg::dp_cmd_t    cmd_o
);

  lirs_pkg::state_e                state_q, state_d;
  logic [lirs_pkg::CntBits-1:0]    bit_cnt_q, bit_cnt_d;
  logic [lirs_pkg::CntBits-1:0]    out_cnt_q, out_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lirs_pkg::StIdle;
      bit_cnt_q <= '0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    bit_cnt_d  = bit_cnt_q;
    out_cnt_d  = out_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lirs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          out_cnt_d     = '0;
          state_d       = lirs_pkg::StChk;
        end
      end
      lirs_pkg::StChk: begin
        if (status_i.resid_lt_dst &&
            out_cnt_q != lirs_pkg::CntBits'(lirs_pkg::MaxOut)) begin
          cmd_o.start_div = 1'b1;
          bit_cnt_d       = '0;
          state_d         = lirs_pkg::StDiv;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = lirs_pkg::StIdle;
        end
      end
      lirs_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        bit_cnt_d      = bit_cnt_q + 1'b1;
        if (bit_cnt_q == lirs_pkg::CntBits'(lirs_pkg::QuoBits - 1)) begin
          state_d = lirs_pkg::StMul;
        end
      end
      lirs_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = lirs_pkg::StPut;
      end
      lirs_pkg::StPut: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = !status_i.next_lt_dst ||
                       out_cnt_q == lirs_pkg::CntBits'(lirs_pkg::MaxOut - 1);
          out_cnt_d  = out_cnt_q + 1'b1;
          state_d    = lirs_pkg::StChk;
        end
      end
      default: begin
        state_d = lirs_pkg::StIdle;
      end
    endcase
  end

  `ASSERT_RST(a_out_cnt_cap, clk_i, rst_ni, out_cnt_q <= lirs_pkg::CntBits'(lirs_pkg::MaxOut))
  `ASSERT_RST(a_emit_needs_room, clk_i, rst_ni, cmd_o.emit |-> status_i.out_free)
  `ASSERT_RST(a_cap_ends_item, clk_i, rst_ni,
              (state_q == lirs_pkg::StChk &&
               out_cnt_q == lirs_pkg::CntBits'(lirs_pkg::MaxOut)) |=>
              state_q == lirs_pkg::StIdle)

endmodule

// File: rtl/core/lirs_dp.sv
// Datapath: config registers, residual, fraction divider, interpolation and output register.
module lirs_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  lirs_pkg::cfg_beat_t  cfg_i,
  input  lirs_pkg::in_beat_t   in_i,
  input  lirs_pkg::dp_cmd_t    cmd_i,
  output lirs_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lirs_pkg::out_beat_t  out_o
);

  localparam int SB = lirs_pkg::SampleBits;
  localparam int RB = lirs_pkg::RateBits;
  localparam int XB = lirs_pkg::ResidBits;
  localparam int QB = lirs_pkg::QuoBits;
  localparam int NB = lirs_pkg::NumBits;
  localparam int PB = lirs_pkg::ProdBits;

  logic [RB-1:0]                src_q, dst_q;
  logic [lirs_pkg::ChanBits-1:0] chan_q;
  logic [XB-1:0]                resid_q;
  logic signed [SB-1:0]         prev_q [2];
  logic signed [SB-1:0]         cur_q  [2];
  logic [RB-1:0]                rem_q;
  logic [QB-1:0]                numsh_q;
  logic [QB-1:0]                quo_q;
  logic signed [PB-1:0]         prod_q [2];
  logic                         out_valid_q;
  lirs_pkg::out_beat_t          out_q;

  logic [XB-1:0]                resid_nxt;
  logic [NB-1:0]                num;
  logic [RB:0]                  trial;
  logic                         trial_ge;
  logic                         two_ch;
  logic signed [SB-1:0]         interp [2];

  assign resid_nxt = resid_q + {1'b0, src_q};
  assign num = {resid_q[RB-1:0], {lirs_pkg::FracBits{1'b0}}} + NB'(dst_q >> 1);
  assign trial = {rem_q, numsh_q[QB-1]};
  assign trial_ge = trial >= {1'b0, dst_q};
  assign two_ch = (chan_q >= 2'd2) && (lirs_pkg::Channels >= 2);

  assign status_o.resid_lt_dst = resid_q < {1'b0, dst_q};
  assign status_o.next_lt_dst  = resid_nxt < {1'b0, dst_q};
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    logic signed [PB-1:0] rnd;
    for (int k = 0; k < 2; k++) begin
      rnd = (prod_q[k] + PB'(signed'(33'sd32768))) >>> lirs_pkg::FracBits;
      interp[k] = prev_q[k] + rnd[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= RB'(44100);
      dst_q       <= RB'(48000);
      chan_q      <= 2'd2;
      resid_q     <= '0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (lirs_pkg::cfg_reg_e'(cfg_i.index))
          lirs_pkg::CfgSrcRate:   src_q  <= cfg_i.data;
          lirs_pkg::CfgDstRate:   dst_q  <= cfg_i.data;
          lirs_pkg::CfgChanCount: chan_q <= cfg_i.data[lirs_pkg::ChanBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        resid_q <= resid_nxt;
      end else if (cmd_i.finish) begin
        resid_q   <= status_o.resid_lt_dst ? '0 : resid_q - {1'b0, dst_q};
        prev_q[0] <= cur_q[0];
        prev_q[1] <= cur_q[1];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q[0] <= in_i.sample_ch0;
      cur_q[1] <= in_i.sample_ch1;
    end
    if (cmd_i.start_div) begin
      rem_q   <= num[NB-1:QB];
      numsh_q <= num[QB-1:0];
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q   <= trial_ge ? RB'(trial - {1'b0, dst_q}) : trial[RB-1:0];
      numsh_q <= {numsh_q[QB-2:0], 1'b0};
      quo_q   <= {quo_q[QB-2:0], trial_ge};
    end
    if (cmd_i.mul) begin
      for (int k = 0; k < 2; k++) begin
        prod_q[k] <= PB'(($signed({cur_q[k][SB-1], cur_q[k]}) -
                          $signed({prev_q[k][SB-1], prev_q[k]})) *
                         $signed({1'b0, quo_q}));
      end
    end
    if (cmd_i.emit) begin
      out_q.out_ch0 <= interp[0];
      out_q.out_ch1 <= two_ch ? interp[1] : '0;
      out_q.last    <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/linear_interp_resampler_top.sv
// Each output: check, 17-step fraction divider, multiply, output load; the output load
// waits while the output register is still full. A new input beat is taken only after
// the last output of the previous one is loaded. The shared radix-2 divider sets the pace.
// Output register lets the next fraction compute while a result waits.
// Async active-low reset: rates 44100/48000, two channels, residual and history zero.
module linear_interp_resampler_top (
  input logic          clk_i,
  input logic          rst_ni,
  lirs_stream_if.sink   cfg_i,
  lirs_stream_if.sink   in_i,
  lirs_stream_if.source out_o
);

  lirs_pkg::dp_cmd_t    cmd;
  lirs_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  lirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lirs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.data),
    .in_i        (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_o.data)
  );

endmodule

// File: tb/tb_linear_interp_resampler_top.sv
// Self-checking testbench for linear_interp_resampler_top: directed and random frames.
`timescale 1ns / 100ps

module tb_linear_interp_resampler_top;

  localparam int                    HoldCycles = 400;
  localparam int                    SettleCycles = 40;
  localparam int                    CycleLimit = 2_000_000;
  localparam logic [lirs_pkg::CfgIdxBits-1:0] CfgUnused = 2'd3;
  localparam longint unsigned       ResidMask = (64'd1 << lirs_pkg::ResidBits) - 1;

  class resample_scoreboard;
    logic [lirs_pkg::RateBits-1:0]          src_rate;
    logic [lirs_pkg::RateBits-1:0]          dst_rate;
    logic [lirs_pkg::ChanBits-1:0]          chan_count;
    logic signed [lirs_pkg::SampleBits-1:0] hist [2];
    logic [lirs_pkg::ResidBits-1:0]         resid;
    lirs_pkg::out_beat_t                    due_beats [$];
    int                                     errors;
    int                                     frames_in;
    int                                     beats_out;

    function new();
      src_rate   = 18'd44100;
      dst_rate   = 18'd48000;
      chan_count = 2'd2;
      hist[0]    = '0;
      hist[1]    = '0;
      resid      = '0;
      errors     = 0;
      frames_in  = 0;
      beats_out  = 0;
    endfunction

    function void write_reg(lirs_pkg::cfg_beat_t b);
      case (b.index)
        lirs_pkg::CfgSrcRate:   src_rate = b.data;
        lirs_pkg::CfgDstRate:   dst_rate = b.data;
        lirs_pkg::CfgChanCount: chan_count = b.data[lirs_pkg::ChanBits-1:0];
        default: ;
      endcase
    endfunction

    // prev + floor(((cur - prev) * frac + 2^15) / 2^16)
    function logic signed [lirs_pkg::SampleBits-1:0] lerp(
        logic signed [lirs_pkg::SampleBits-1:0] a,
        logic signed [lirs_pkg::SampleBits-1:0] b,
        longint frac);
      longint prod;
      prod = (longint'(b) - longint'(a)) * frac;
      return lirs_pkg::SampleBits'(longint'(a) + ((prod + 64'sd32768) >>> lirs_pkg::FracBits));
    endfunction

    function void predict_frame(lirs_pkg::in_beat_t f);
      longint unsigned     r;
      longint unsigned     r_next;
      longint unsigned     frac;
      int                  n;
      bit                  two_ch;
      lirs_pkg::out_beat_t o;
      two_ch = (chan_count >= 2);
      r = resid;
      n = 0;
      frames_in++;
      while (r < dst_rate && n < lirs_pkg::MaxOut) begin
        frac = ((r << lirs_pkg::FracBits) + (dst_rate >> 1)) / dst_rate;
        r_next = (r + src_rate) & ResidMask;
        o.out_ch0 = lerp(hist[0], f.sample_ch0, frac);
        o.out_ch1 = two_ch ? lerp(hist[1], f.sample_ch1, frac) : '0;
        o.last = !(r_next < dst_rate && n + 1 < lirs_pkg::MaxOut);
        due_beats.push_back(o);
        n++;
        r = r_next;
      end
      if (r >= dst_rate) begin
        r = r - dst_rate;
      end else begin
        r = 0;
      end
      resid = r[lirs_pkg::ResidBits-1:0];
      hist[0] = f.sample_ch0;
      hist[1] = f.sample_ch1;
    endfunction

    function void check_beat(lirs_pkg::out_beat_t got);
      lirs_pkg::out_beat_t want;
      beats_out++;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= 100) begin
          $display("%0t: unexpected output beat: expected none, got ch0=%0d ch1=%0d last=%0b",
                   $time, got.out_ch0, got.out_ch1, got.last);
        end
        return;
      end
      want = due_beats.pop_front();
      if (got.out_ch0 !== want.out_ch0 || got.out_ch1 !== want.out_ch1 ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 100) begin
          $display("%0t: output beat mismatch: expected ch0=%0d ch1=%0d last=%0b,",
                   $time, want.out_ch0, want.out_ch1, want.last,
                   " got ch0=%0d ch1=%0d last=%0b",
                   got.out_ch0, got.out_ch1, got.last);
        end
      end
    endfunction

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lirs_stream_if #(.payload_t(lirs_pkg::cfg_beat_t)) cfg_if ();
  lirs_stream_if #(.payload_t(lirs_pkg::in_beat_t))  in_if ();
  lirs_stream_if #(.payload_t(lirs_pkg::out_beat_t)) out_if ();

  linear_interp_resampler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  resample_scoreboard sb = new();

  int                 cycles = 0;
  int                 settings = 0;
  bit                 steady = 1'b0;
  bit                 hold_req = 1'b0;
  bit                 hold_seen = 1'b0;
  lirs_pkg::in_beat_t last_frame = '0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d beats outstanding", $time, sb.pending());
      $display("linear_interp_resampler_top test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.data);
      end
      if (in_if.valid && in_if.ready) begin
        sb.predict_frame(in_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_beat(out_if.data);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 60);
  endfunction

  function automatic logic signed [lirs_pkg::SampleBits-1:0] pick_sample(
      logic signed [lirs_pkg::SampleBits-1:0] near);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return lirs_pkg::SampleBits'($urandom);
    end
    if (roll < 70) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return near + lirs_pkg::SampleBits'($urandom_range(0, 511) - 256);
  endfunction

  // output side: random stalls, steady stretches, one long hold-off on request
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        hold_seen = 1'b1;
      end else if (steady) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  task automatic write_reg(input logic [lirs_pkg::CfgIdxBits-1:0] idx,
                           input logic [lirs_pkg::RateBits-1:0] val);
    lirs_pkg::cfg_beat_t beat;
    beat.index = idx;
    beat.data = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= beat;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic set_config(input logic [lirs_pkg::RateBits-1:0] src,
                            input logic [lirs_pkg::RateBits-1:0] dst,
                            input logic [lirs_pkg::ChanBits-1:0] chans);
    write_reg(lirs_pkg::CfgSrcRate, src);
    write_reg(lirs_pkg::CfgDstRate, dst);
    write_reg(lirs_pkg::CfgChanCount, lirs_pkg::RateBits'(chans));
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // valid stays high into the next beat unless a gap follows
  task automatic send(input logic signed [lirs_pkg::SampleBits-1:0] ch0,
                      input logic signed [lirs_pkg::SampleBits-1:0] ch1);
    lirs_pkg::in_beat_t f;
    f.sample_ch0 = ch0;
    f.sample_ch1 = ch1;
    in_if.valid <= 1'b1;
    in_if.data <= f;
    do @(posedge clk_i); while (!in_if.ready);
    last_frame = f;
    if (!steady) begin
      idle_gap(pick_gap());
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_frames(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_req = 1'b1;
      end
      send(pick_sample(last_frame.sample_ch0), pick_sample(last_frame.sample_ch1));
    end
    drain();
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rates, full-scale swings
    send(16'sh7FFF, 16'sh8000);
    send(16'sh8000, 16'sh7FFF);
    send(16'sh7FFF, 16'sh7FFF);
    send(16'sh8000, 16'sh8000);
    send(16'sh0000, 16'sh0000);
    send(16'sh0001, 16'shFFFF);
    drain();

    // mono: channel 1 output forced to zero, history still kept
    set_config(18'd44100, 18'd48000, 2'd1);
    send(16'sh3039, 16'shF752);
    send(16'sh8000, 16'sh7FFF);
    drain();
    set_config(18'd44100, 18'd48000, 2'd0);
    send(16'sh7FFF, 16'sh1234);
    drain();
    write_reg(CfgUnused, 18'h3FFFF);
    set_config(18'd48000, 18'd44100, 2'd3);
    send(16'sh8000, 16'sh8000);
    drain();

    // zero output rate: no beats, residual held
    set_config(18'd44100, 18'd0, 2'd2);
    send(16'sh1111, 16'sh2222);
    send(16'shEEEE, 16'shDDDD);
    drain();

    // zero input rate: capped burst, residual cleared
    set_config(18'd0, 18'd48000, 2'd2);
    send(16'sh7FFF, 16'sh8000);
    drain();

    set_config(18'd8000, 18'd192000, 2'd2);
    send(16'sh8000, 16'sh7FFF);
    send(16'sh7FFF, 16'sh8000);
    drain();
    set_config(18'd192000, 18'd8000, 2'd2);
    send(16'sh7FFF, 16'sh8000);
    send(16'sh8000, 16'sh7FFF);
    send(16'sh4000, 16'shC000);
    send(16'sh0000, 16'sh0000);
    drain();
    set_config(18'd192000, 18'd192000, 2'd2);
    send(16'sh7FFF, 16'sh0000);
    send(16'sh8000, 16'shFFFF);
    drain();
    set_config(18'h3FFFF, 18'h3FFFF, 2'd2);
    send(16'sh1234, 16'sh8000);
    send(16'shFEDC, 16'sh7FFF);
    drain();

    // random content over several rate settings
    set_config(18'd44100, 18'd48000, 2'd2);
    run_frames(35, 5);
    steady = 1'b1;
    set_config(18'd48000, 18'd44100, 2'd1);
    run_frames(25, -1);
    steady = ($urandom_range(0, 4) == 0);
    set_config(18'd8000, 18'd192000, 2'($urandom_range(0, 3)));
    run_frames(8, -1);
    steady = ($urandom_range(0, 4) == 0);
    set_config(18'd192000, 18'd8000, 2'd2);
    run_frames(40, -1);
    repeat (4) begin
      steady = ($urandom_range(0, 4) == 0);
      set_config(lirs_pkg::RateBits'($urandom_range(8000, 192000)),
                 lirs_pkg::RateBits'($urandom_range(8000, 192000)),
                 2'($urandom_range(0, 3)));
      run_frames(15, -1);
    end

    $display("Sent %0d input frames over %0d rate/channel settings, checked %0d output beats.",
             sb.frames_in, settings + 1, sb.beats_out);
    $display("Output hold-off of %0d cycles exercised: %0b.", HoldCycles, hold_seen);
    if (sb.errors == 0) begin
      $display("linear_interp_resampler_top test passed");
    end else begin
      $display("linear_interp_resampler_top test failed");
    end
    $finish;
  end

endmodule
